FILE: hdl/msra_pkg.sv
`timescale 1ns / 1ps
package msra_pkg;

  localparam int unsigned ACC_W    = 64;
  localparam int unsigned MOD_W    = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned ROW_W    = 6;
  // Remainder bits retired per cycle by the reduction unit
  localparam int unsigned MOD_STEP = 4;
  localparam logic [MOD_W-1:0] MODULUS_RST = 16'd65521;
  localparam logic [MOD_W-1:0] MODULUS_MIN = 16'd2;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_ACC   = 2'd2,
    FUNC_FLUSH = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_ACC,
    OP_FLUSH,
    OP_EMPTY
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACC_WR,
    ST_FL_RD,
    ST_FL_START,
    ST_FL_WAIT,
    ST_FL_NEXT,
    ST_FL_END
  } back_state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [MOD_W-1:0] coefficient;
    logic [MOD_W-1:0] element;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] out_column;
    logic [MOD_W-1:0] entry_value;
    logic             last;
    logic             empty_res;
  } res_t;

  typedef struct packed {
    op_e              op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [MOD_W-1:0] coefficient;
    logic [MOD_W-1:0] element;
  } job_t;

endpackage

FILE: hdl/modular_sparse_row_accumulator.sv
`timescale 1ns / 1ps
// Modular sparse row accumulator: a ROW_COUNT x ROW_WIDTH block of 64-bit
// accumulators in one RAM, driven by clear, load, scaled accumulate and
// flush commands. Commands land in a two-entry queue, so the input side keeps
// taking transfers while the execution side works or the result register
// waits. Steps on the execution side, set by its single RAM port and the
// remainder unit: a load or ignored command is finished as it is taken, an
// accumulate reads, then adds and writes back, a clear takes the command,
// then writes each word in turn, and a flush takes the command, then for
// each word does a read, a start, the 4-bit-per-cycle remainder unit, its
// done flag and a step to pass the entry on, then sends the last result,
// with stalls on the output on top. The accumulators are not cleared by
// reset; clear or load a row before flushing it. A modulus below 2
// reduces as 2.
module modular_sparse_row_accumulator #(
  parameter int unsigned ROW_COUNT = 64,
  parameter int unsigned ROW_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msra_pkg::cmd_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msra_pkg::res_t out_data_o
);
  import msra_pkg::*;

  logic [MOD_W-1:0] modulus_q;
  logic             job_valid, job_pop;
  job_t             job;

  // Modulus register: hold the reset value until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // Front: accept and classify commands
  msra_front #(.ROW_COUNT(ROW_COUNT), .ROW_WIDTH(ROW_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // Back: execute against the accumulator RAM and drive results
  msra_back #(.ROW_COUNT(ROW_COUNT), .ROW_WIDTH(ROW_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_res |->
      out_data_o.last && out_data_o.entry_value == '0 && out_data_o.out_column == '0)
    else $error("empty result malformed");

  a_nonzero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.empty_res |-> out_data_o.entry_value != '0)
    else $error("zero entry emitted");

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.empty_res |->
      (out_data_o.entry_value < modulus_q) ||
      (modulus_q < MODULUS_MIN && out_data_o.entry_value < MODULUS_MIN))
    else $error("entry not reduced");
`endif

endmodule

FILE: hdl/msra_ram.sv
`timescale 1ns / 1ps
module msra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/msra_rem.sv
`timescale 1ns / 1ps
module msra_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] rem_o
);
  import msra_pkg::*;

  localparam int unsigned STEPS = ACC_W / MOD_STEP;
  localparam int unsigned CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [ACC_W-1:0] dvd_q, dvd_d;
  logic [MOD_W-1:0] rem_q, rem_d;
  logic [MOD_W-1:0] div_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  // Restoring division, MOD_STEP bits per cycle; remainder stays below divisor
  always_comb begin
    logic [MOD_W:0] t;
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int i = 0; i < MOD_STEP; i++) begin
      t = {rem_d, dvd_d[ACC_W-1]};
      dvd_d = {dvd_d[ACC_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/msra_front.sv
`timescale 1ns / 1ps
module msra_front #(
  parameter int unsigned ROW_COUNT = 64,
  parameter int unsigned ROW_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msra_pkg::cmd_t in_data_i,
  output logic           job_valid_o,
  output msra_pkg::job_t job_o,
  input  logic           job_pop_i
);
  import msra_pkg::*;

  job_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  job_t       cls;
  logic       row_ok, col_ok, push, pop;

  assign row_ok = int'(in_data_i.row) < ROW_COUNT;
  assign col_ok = int'(in_data_i.column) < ROW_WIDTH;

  // Classify: out-of-range and no-effect commands become NOP or EMPTY
  always_comb begin
    cls.row         = in_data_i.row;
    cls.column      = in_data_i.column;
    cls.coefficient = in_data_i.coefficient;
    cls.element     = in_data_i.element;
    case (in_data_i.func)
      FUNC_CLEAR: cls.op = row_ok ? OP_CLEAR : OP_NOP;
      FUNC_LOAD:  cls.op = (row_ok && col_ok) ? OP_LOAD : OP_NOP;
      FUNC_ACC:   cls.op = (row_ok && col_ok && in_data_i.coefficient != '0) ? OP_ACC : OP_NOP;
      FUNC_FLUSH: cls.op = row_ok ? OP_FLUSH : OP_EMPTY;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_pop_i && job_valid_o;
  assign job_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: hdl/msra_back.sv
`timescale 1ns / 1ps
module msra_back #(
  parameter int unsigned ROW_COUNT = 64,
  parameter int unsigned ROW_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    modulus_i,
  input  logic           job_valid_i,
  input  msra_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msra_pkg::res_t out_data_o
);
  import msra_pkg::*;

  localparam int unsigned DEPTH  = ROW_COUNT * ROW_WIDTH;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COL_AW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

  function automatic logic [ADDR_W-1:0] word_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * ROW_WIDTH + int'(c));
  endfunction

  back_state_e      state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_AW-1:0] col_q, col_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic             pend_valid_q, pend_valid_d;
  logic [COL_W-1:0] pend_col_q, pend_col_d;
  logic [MOD_W-1:0] pend_val_q, pend_val_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  logic             we, re, rem_start, rem_done, out_free, col_last;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ACC_W-1:0] wdata, rdata;
  logic [MOD_W-1:0] rem, eff_mod, neg;

  assign eff_mod  = (modulus_i < MODULUS_MIN) ? MODULUS_MIN : modulus_i;
  assign neg      = modulus_i - job_i.coefficient;
  assign out_free = !out_valid_q || out_ready_i;
  assign col_last = (col_q == COL_AW'(ROW_WIDTH - 1));

  msra_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  msra_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rdata),
    .divisor_i  (eff_mod),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    addr_d       = addr_q;
    prod_d       = prod_q;
    pend_valid_d = pend_valid_q;
    pend_col_d   = pend_col_q;
    pend_val_d   = pend_val_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    job_pop_o    = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = addr_q;
    raddr        = word_addr(row_q, COL_W'(col_q));
    wdata        = '0;
    rem_start    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          case (job_i.op)
            OP_CLEAR: begin
              row_d   = job_i.row;
              col_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_LOAD: begin
              we    = 1'b1;
              waddr = word_addr(job_i.row, job_i.column);
              wdata = ACC_W'(job_i.element);
            end
            OP_ACC: begin
              re      = 1'b1;
              raddr   = word_addr(job_i.row, job_i.column);
              addr_d  = raddr;
              prod_d  = PROD_W'(neg) * PROD_W'(job_i.element);
              state_d = ST_ACC_WR;
            end
            OP_FLUSH: begin
              row_d        = job_i.row;
              col_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_FL_RD;
            end
            OP_EMPTY: begin
              if (out_free) begin
                out_valid_d = 1'b1;
                out_d       = '{out_column: '0, entry_value: '0, last: 1'b1, empty_res: 1'b1};
              end else begin
                job_pop_o = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = word_addr(row_q, COL_W'(col_q));
        if (col_last) state_d = ST_IDLE;
        else          col_d   = col_q + 1'b1;
      end
      ST_ACC_WR: begin
        we      = 1'b1;
        wdata   = rdata + ACC_W'(prod_q);
        state_d = ST_IDLE;
      end
      ST_FL_RD: begin
        re      = 1'b1;
        state_d = ST_FL_START;
      end
      ST_FL_START: begin
        rem_start = 1'b1;
        state_d   = ST_FL_WAIT;
      end
      ST_FL_WAIT: begin
        if (rem_done) state_d = ST_FL_NEXT;
      end
      ST_FL_NEXT: begin
        if (rem == '0 || !pend_valid_q || out_free) begin
          if (rem != '0) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d = '{out_column: pend_col_q, entry_value: pend_val_q,
                        last: 1'b0, empty_res: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_col_d   = COL_W'(col_q);
            pend_val_d   = rem;
          end
          if (col_last) begin
            state_d = ST_FL_END;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = ST_FL_RD;
          end
        end
      end
      ST_FL_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_valid_q) begin
            out_d = '{out_column: pend_col_q, entry_value: pend_val_q,
                      last: 1'b1, empty_res: 1'b0};
          end else begin
            out_d = '{out_column: '0, entry_value: '0, last: 1'b1, empty_res: 1'b1};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    addr_q     <= addr_d;
    prod_q     <= prod_d;
    pend_col_q <= pend_col_d;
    pend_val_q <= pend_val_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: bench/tb_modular_sparse_row_accumulator.sv
`timescale 1ns / 1ps
module tb_modular_sparse_row_accumulator;
  import msra_pkg::*;

  localparam int unsigned ROWS = 64;
  localparam int unsigned COLS = 64;
  // Idle percentage on each side
  localparam int unsigned IDLE_PCT = 18;
  // Longest flush plus queued work, in cycles
  localparam int unsigned SETTLE_CYCLES = 3000;
  localparam int unsigned RANDOM_ITEMS = 200;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  cmd_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_data_o;

  modular_sparse_row_accumulator #(
    .ROW_COUNT(ROWS),
    .ROW_WIDTH(COLS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // Shadow copy of the accumulator block and the modulus register
  logic [ACC_W-1:0] acc_shadow [ROWS][COLS];
  // A word is known once cleared or loaded; flushes only touch fully known rows
  bit               word_known [ROWS][COLS];
  logic [MOD_W-1:0] modulus_q;
  res_t             pending_entries[$];
  int unsigned      errors;
  int unsigned      sent;
  bit               quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic cmd_t make_cmd(func_e f, int unsigned r, int unsigned c,
                                    int unsigned coef, int unsigned elem);
    cmd_t cmd;
    cmd.func        = f;
    cmd.row         = r[ROW_W-1:0];
    cmd.column      = c[COL_W-1:0];
    cmd.coefficient = coef[MOD_W-1:0];
    cmd.element     = elem[MOD_W-1:0];
    return cmd;
  endfunction

  function automatic bit row_known(int unsigned r);
    for (int j = 0; j < COLS; j++) begin
      if (!word_known[r][j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Update the shadow state and queue the entries a command should emit
  task automatic apply_cmd(cmd_t c);
    logic [MOD_W-1:0] neg;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] e;
    res_t r;
    int n;
    n = 0;
    case (c.func)
      FUNC_CLEAR: begin
        for (int j = 0; j < COLS; j++) begin
          acc_shadow[c.row][j] = '0;
          word_known[c.row][j] = 1'b1;
        end
      end
      FUNC_LOAD: begin
        acc_shadow[c.row][c.column] = {48'd0, c.element};
        word_known[c.row][c.column] = 1'b1;
      end
      FUNC_ACC: begin
        if (c.coefficient != '0) begin
          neg  = modulus_q - c.coefficient;
          prod = PROD_W'(neg) * PROD_W'(c.element);
          acc_shadow[c.row][c.column] = acc_shadow[c.row][c.column] + ACC_W'(prod);
        end
      end
      default: begin
        m = (modulus_q < MODULUS_MIN) ? ACC_W'(MODULUS_MIN) : ACC_W'(modulus_q);
        for (int j = 0; j < COLS; j++) begin
          e = acc_shadow[c.row][j] % m;
          if (e != '0) begin
            r.out_column  = COL_W'(j);
            r.entry_value = e[MOD_W-1:0];
            r.last        = 1'b0;
            r.empty_res   = 1'b0;
            pending_entries.insert(pending_entries.size(), r);
            n++;
          end
        end
        if (n == 0) begin
          r = '0;
          r.last      = 1'b1;
          r.empty_res = 1'b1;
          pending_entries.insert(pending_entries.size(), r);
        end else begin
          pending_entries[pending_entries.size()-1].last = 1'b1;
        end
      end
    endcase
  endtask

  // Present one command and hold it until the transfer
  task automatic send_cmd(cmd_t c);
    bit took;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    apply_cmd(c);
    sent++;
  endtask

  // Wait until every entry has arrived and the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [MOD_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    modulus_q = v;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sample at the falling edge: inputs and outputs are both settled there
  initial begin
    res_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_entries.size() == 0) begin
          report_mismatch("unexpected entry, column", out_data_o.out_column, 0);
        end else begin
          want = pending_entries.pop_front();
          if (out_data_o.out_column != want.out_column)
            report_mismatch("out_column", out_data_o.out_column, want.out_column);
          if (out_data_o.entry_value != want.entry_value)
            report_mismatch("entry_value", out_data_o.entry_value, want.entry_value);
          if (out_data_o.last != want.last)
            report_mismatch("last", out_data_o.last, want.last);
          if (out_data_o.empty_res != want.empty_res)
            report_mismatch("empty_res", out_data_o.empty_res, want.empty_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Edge values of every field, the zero coefficient, an over-range
  // coefficient and the empty flush
  task automatic test_directed();
    send_cmd(make_cmd(FUNC_CLEAR, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_FLUSH, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_LOAD, 0, 0, 0, 65535));
    send_cmd(make_cmd(FUNC_LOAD, 0, 63, 0, 0));
    send_cmd(make_cmd(FUNC_ACC, 0, 63, 1, 65535));
    send_cmd(make_cmd(FUNC_ACC, 0, 63, 0, 65535));
    send_cmd(make_cmd(FUNC_ACC, 0, 5, 65535, 65535));
    send_cmd(make_cmd(FUNC_ACC, 0, 6, 65521, 1234));
    send_cmd(make_cmd(FUNC_FLUSH, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_CLEAR, 63, 63, 65535, 65535));
    send_cmd(make_cmd(FUNC_LOAD, 63, 5, 0, 65521));
    send_cmd(make_cmd(FUNC_FLUSH, 63, 63, 65535, 65535));
    send_cmd(make_cmd(FUNC_LOAD, 63, 62, 0, 1));
    send_cmd(make_cmd(FUNC_FLUSH, 63, 0, 0, 0));
    drain();
  endtask

  task automatic test_modulus_extremes();
    logic [MOD_W-1:0] mods [4];
    mods = '{16'd0, 16'd1, 16'd65535, 16'd2};
    foreach (mods[k]) begin
      write_modulus(mods[k]);
      send_cmd(make_cmd(FUNC_CLEAR, 1, 0, 0, 0));
      send_cmd(make_cmd(FUNC_LOAD, 1, 3, 0, 65535));
      send_cmd(make_cmd(FUNC_LOAD, 1, 4, 0, 65534));
      send_cmd(make_cmd(FUNC_ACC, 1, 7, 3, 65535));
      send_cmd(make_cmd(FUNC_FLUSH, 1, 0, 0, 0));
      drain();
    end
  endtask

  function automatic int unsigned rand_value();
    case ($urandom_range(3))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Mostly clear-update-flush sequences, with loose commands mixed in
  task automatic run_random(int unsigned items);
    int unsigned stop;
    int unsigned r;
    int unsigned ops;
    int unsigned coef;
    stop = sent + items;
    while (sent < stop) begin
      r = $urandom_range(ROWS-1);
      if ($urandom_range(9) < 8) begin
        if (!row_known(r) || $urandom_range(3) == 0)
          send_cmd(make_cmd(FUNC_CLEAR, r, $urandom_range(63), rand_value(), rand_value()));
        ops = $urandom_range(12, 1);
        repeat (ops) begin
          coef = ($urandom_range(7) == 0) ? 0 : rand_value();
          send_cmd(make_cmd($urandom_range(2) == 0 ? FUNC_LOAD : FUNC_ACC, r,
                            $urandom_range(COLS-1), coef, rand_value()));
        end
        send_cmd(make_cmd(FUNC_FLUSH, r, $urandom_range(63), rand_value(), rand_value()));
      end else begin
        // Loose command; a flush of a partly unknown row becomes a clear
        case ($urandom_range(3))
          0: send_cmd(make_cmd(FUNC_CLEAR, r, $urandom_range(63), rand_value(), rand_value()));
          1: send_cmd(make_cmd(FUNC_LOAD, r, $urandom_range(63), rand_value(), rand_value()));
          2: send_cmd(make_cmd(FUNC_ACC, r, $urandom_range(63), rand_value(), rand_value()));
          default: begin
            if (row_known(r))
              send_cmd(make_cmd(FUNC_FLUSH, r, $urandom_range(63), 0, 0));
            else
              send_cmd(make_cmd(FUNC_CLEAR, r, 0, 0, 0));
          end
        endcase
      end
    end
    drain();
  endtask

  task automatic test_random();
    write_modulus(MODULUS_RST);
    run_random(RANDOM_ITEMS / 4);
    write_modulus(16'($urandom_range(20, 3)));
    run_random(RANDOM_ITEMS / 4);
    // Long stretch with both sides always willing
    quiet = 1'b1;
    write_modulus(16'($urandom_range(65535, 2)));
    run_random(RANDOM_ITEMS / 4);
    quiet = 1'b0;
    write_modulus(16'd65535);
    run_random(RANDOM_ITEMS / 4);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    errors      = 0;
    sent        = 0;
    quiet       = 1'b0;
    modulus_q   = MODULUS_RST;
    for (int i = 0; i < ROWS; i++) begin
      for (int j = 0; j < COLS; j++) begin
        acc_shadow[i][j] = '0;
        word_known[i][j] = 1'b0;
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_modulus_extremes();
    test_random();
    if (errors == 0 && pending_entries.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
